// ----- rtl/core/one_shot_timer_pool_defines.svh -----
// Assertion macros for the one-shot timer pool.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef ONE_SHOT_TIMER_POOL_DEFINES_SVH
`define ONE_SHOT_TIMER_POOL_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define OSTP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define OSTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ostp_pkg.sv -----
// Shared types and constants for the one-shot timer pool.
// No dependencies.
package ostp_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int FUNC_W      = 2;
    localparam int KIND_W      = 3;
    localparam int HID_W       = 8;
    localparam int TMO_W       = 16;
    localparam int COOKIE_W    = 16;
    localparam int DATA_W      = TMO_W + COOKIE_W + HID_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START  = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_CANCEL = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_STARTED   = 3'd0,
        KIND_DROPPED   = 3'd1,
        KIND_CANCELED  = 3'd2,
        KIND_FIRED     = 3'd3,
        KIND_IDLE_TICK = 3'd4
    } kind_t;

    // One slot's record as held in the slot RAM
    typedef struct packed {
        logic [TMO_W-1:0]    tmo;
        logic [COOKIE_W-1:0] cookie;
        logic [HID_W-1:0]    hid;
    } slot_rec_t;

    // Slot-order RAM address select
    typedef enum logic [1:0] {
        OA_N     = 2'd0,
        OA_BOUND = 2'd1,
        OA_FREE  = 2'd2
    } ord_sel_t;

    // Slot RAM write mode
    typedef enum logic [1:0] {
        DW_NONE = 2'd0,
        DW_DEC  = 2'd1,
        DW_CLR  = 2'd2,
        DW_NEW  = 2'd3
    } data_wr_t;

    // Terminal result to emit
    typedef enum logic [2:0] {
        EMIT_NONE     = 3'd0,
        EMIT_STARTED  = 3'd1,
        EMIT_DROPPED  = 3'd2,
        EMIT_CANCELED = 3'd3,
        EMIT_TICK_END = 3'd4
    } emit_t;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_DISPATCH  = 4'd1,
        ST_START_RD  = 4'd2,
        ST_START_WR  = 4'd3,
        ST_WALK_RD   = 4'd4,
        ST_WALK_SLOT = 4'd5,
        ST_WALK_EVAL = 4'd6,
        ST_SWAP_A    = 4'd7,
        ST_SWAP_B    = 4'd8
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic     latch;
        ord_sel_t ord_sel;
        logic     ord_we;
        logic     cap_slot;
        logic     cap_other;
        data_wr_t data_wr;
        logic     n_inc;
        logic     release_slot;
        logic     active_inc;
        logic     fire;
        emit_t    emit;
    } ostp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        func_t func;
        logic  pool_full;
        logic  walk_done;
        logic  tmo_zero;
        logic  hid_match;
    } ostp_status_t;

endpackage

// ----- rtl/core/ostp_ram.sv -----
// Generic single-port RAM with registered read (read-before-write).
// No dependencies.
module ostp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage and read register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ostp_ctrl.sv -----
// Sequencer for the timer pool: decodes requests and walks the active list.
// Depends on ostp_pkg.
module ostp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ostp_pkg::ostp_status_t status,
    output ostp_pkg::ostp_cmd_t    cmd,
    output logic                  busy
);
    import ostp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.func)
                    FUNC_START:
                    begin
                        state_next = status.pool_full ? ST_IDLE : ST_START_RD;
                    end
                    FUNC_TICK, FUNC_CANCEL:
                    begin
                        state_next = ST_WALK_RD;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_START_RD:  state_next = ST_START_WR;
            ST_START_WR:  state_next = ST_IDLE;
            ST_WALK_RD:
            begin
                state_next = status.walk_done ? ST_IDLE : ST_WALK_SLOT;
            end
            ST_WALK_SLOT: state_next = ST_WALK_EVAL;
            ST_WALK_EVAL:
            begin
                if (status.func == FUNC_TICK && status.tmo_zero)
                begin
                    state_next = ST_SWAP_A;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_SWAP_A:    state_next = ST_SWAP_B;
            ST_SWAP_B:    state_next = ST_WALK_RD;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd              = '0;
        cmd.ord_sel      = OA_N;
        cmd.data_wr      = DW_NONE;
        cmd.emit         = EMIT_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.latch = start;
            end
            ST_DISPATCH:
            begin
                if (status.func == FUNC_START && status.pool_full)
                begin
                    cmd.emit = EMIT_DROPPED;
                end
            end
            ST_START_RD:
            begin
                cmd.ord_sel = OA_FREE;
            end
            ST_START_WR:
            begin
                cmd.cap_slot   = 1'b1;
                cmd.data_wr    = DW_NEW;
                cmd.active_inc = 1'b1;
                cmd.emit       = EMIT_STARTED;
            end
            ST_WALK_RD:
            begin
                if (status.walk_done)
                begin
                    cmd.emit = (status.func == FUNC_TICK) ? EMIT_TICK_END : EMIT_CANCELED;
                end
            end
            ST_WALK_SLOT:
            begin
                cmd.cap_slot = 1'b1;
            end
            ST_WALK_EVAL:
            begin
                if (status.func == FUNC_TICK)
                begin
                    if (status.tmo_zero)
                    begin
                        // release: fetch the boundary entry for the swap
                        cmd.fire    = 1'b1;
                        cmd.ord_sel = OA_BOUND;
                    end
                    else
                    begin
                        cmd.data_wr = DW_DEC;
                        cmd.n_inc   = 1'b1;
                    end
                end
                else
                begin
                    cmd.data_wr = status.hid_match ? DW_CLR : DW_NONE;
                    cmd.n_inc   = 1'b1;
                end
            end
            ST_SWAP_A:
            begin
                cmd.cap_other = 1'b1;
                cmd.ord_sel   = OA_BOUND;
                cmd.ord_we    = 1'b1;
            end
            ST_SWAP_B:
            begin
                cmd.ord_sel      = OA_N;
                cmd.ord_we       = 1'b1;
                cmd.release_slot = 1'b1;
                cmd.n_inc        = 1'b1;
            end
            default:
            begin
                cmd.latch = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- rtl/core/ostp_dp.sv -----
// Datapath for the timer pool: slot-order and slot RAMs, walk counters,
// pending fired result and result registers. Depends on ostp_pkg, ostp_ram.
module ostp_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ostp_pkg::ostp_cmd_t                 cmd,
    input  logic [ostp_pkg::FUNC_W-1:0]        func,
    input  logic [ostp_pkg::HID_W-1:0]         handler_id,
    input  logic [ostp_pkg::TMO_W-1:0]         timeout,
    input  logic [ostp_pkg::COOKIE_W-1:0]      cookie,
    output ostp_pkg::ostp_status_t              status,
    output logic                               result_valid,
    output logic [ostp_pkg::KIND_W-1:0]        kind,
    output logic [ostp_pkg::HID_W-1:0]         fired_handler,
    output logic [ostp_pkg::COOKIE_W-1:0]      fired_cookie,
    output logic                               last
);
    import ostp_pkg::*;

    // Latched request
    func_t               func_reg;
    logic [HID_W-1:0]    hid_reg;
    logic [TMO_W-1:0]    tmo_reg;
    logic [COOKIE_W-1:0] cookie_reg;

    // Walk state
    logic [CNT_W-1:0]    active_reg, active_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [SLOT_W-1:0]   s_reg, other_reg;
    logic [CNT_W-1:0]    bound;
    logic [CNT_W-1:0]    free_pos;

    // Slot-order RAM and its reset-value overlay
    logic [TIMER_SLOTS-1:0] ord_valid_reg, ord_valid_next;
    logic                   ord_vq_reg;
    logic [SLOT_W-1:0]      ord_aq_reg;
    logic [SLOT_W-1:0]      ord_addr, ord_wdata, ord_q, ord_rdata;

    // Slot RAM
    logic [SLOT_W-1:0] data_addr;
    logic              data_we;
    slot_rec_t         data_wdata, rec;
    logic [DATA_W-1:0] data_q;

    // Pending fired result and output registers
    logic                pend_valid_reg, pend_valid_next;
    logic [HID_W-1:0]    pend_hid_reg;
    logic [COOKIE_W-1:0] pend_cookie_reg;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [HID_W-1:0]    out_hid_reg, out_hid_next;
    logic [COOKIE_W-1:0] out_cookie_reg, out_cookie_next;
    logic                out_last_reg, out_last_next;

    // Boundary of the active region and the free slot below it
    assign bound    = CNT_W'(TIMER_SLOTS) - active_reg;
    assign free_pos = CNT_W'(TIMER_SLOTS - 1) - active_reg;

    // Slot-order addressing
    always_comb
    begin
        case (cmd.ord_sel)
            OA_N:     ord_addr = n_reg[SLOT_W-1:0];
            OA_BOUND: ord_addr = bound[SLOT_W-1:0];
            OA_FREE:  ord_addr = free_pos[SLOT_W-1:0];
            default:  ord_addr = n_reg[SLOT_W-1:0];
        endcase
    end

    assign ord_wdata = (cmd.ord_sel == OA_BOUND) ? s_reg : other_reg;

    ostp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TIMER_SLOTS)
    ) u_ord_ram (
        .clk   (clk),
        .we    (cmd.ord_we),
        .addr  (ord_addr),
        .wdata (ord_wdata),
        .rdata (ord_q)
    );

    // Unwritten entries read as their own position
    assign ord_rdata = ord_vq_reg ? ord_q : ord_aq_reg;

    always_comb
    begin
        ord_valid_next = ord_valid_reg;
        if (cmd.ord_we)
        begin
            ord_valid_next[ord_addr] = 1'b1;
        end
    end

    // Slot RAM access
    assign data_addr = cmd.cap_slot ? ord_rdata : s_reg;
    assign rec       = slot_rec_t'(data_q);
    assign data_we   = (cmd.data_wr != DW_NONE);

    always_comb
    begin
        data_wdata = rec;
        case (cmd.data_wr)
            DW_DEC:  data_wdata.tmo = rec.tmo - TMO_W'(1);
            DW_CLR:  data_wdata.hid = '0;
            DW_NEW:
            begin
                data_wdata.tmo    = tmo_reg;
                data_wdata.cookie = cookie_reg;
                data_wdata.hid    = hid_reg;
            end
            default: data_wdata = rec;
        endcase
    end

    ostp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (data_we),
        .addr  (data_addr),
        .wdata (data_wdata),
        .rdata (data_q)
    );

    // Counters
    always_comb
    begin
        active_next = active_reg;
        if (cmd.active_inc)
        begin
            active_next = active_reg + CNT_W'(1);
        end
        else if (cmd.release_slot)
        begin
            active_next = active_reg - CNT_W'(1);
        end

        n_next = n_reg;
        if (cmd.latch)
        begin
            n_next = bound;
        end
        else if (cmd.n_inc)
        begin
            n_next = n_reg + CNT_W'(1);
        end
    end

    // Result sequencing: a fire is held back until we know if it is last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = 1'b0;
        out_kind_next   = KIND_STARTED;
        out_hid_next    = '0;
        out_cookie_next = '0;
        out_last_next   = 1'b1;

        if (cmd.latch)
        begin
            pend_valid_next = 1'b0;
        end

        if (cmd.fire && rec.hid != '0)
        begin
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = KIND_FIRED;
                out_hid_next    = pend_hid_reg;
                out_cookie_next = pend_cookie_reg;
                out_last_next   = 1'b0;
            end
        end

        case (cmd.emit)
            EMIT_STARTED:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_STARTED;
            end
            EMIT_DROPPED:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_DROPPED;
            end
            EMIT_CANCELED:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_CANCELED;
            end
            EMIT_TICK_END:
            begin
                out_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    out_kind_next   = KIND_FIRED;
                    out_hid_next    = pend_hid_reg;
                    out_cookie_next = pend_cookie_reg;
                end
                else
                begin
                    out_kind_next = KIND_IDLE_TICK;
                end
            end
            default:
            begin
                // no terminal result this cycle
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            n_reg          <= '0;
            ord_valid_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            n_reg          <= n_next;
            ord_valid_reg  <= ord_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ord_vq_reg <= ord_valid_reg[ord_addr];
        ord_aq_reg <= ord_addr;
        if (cmd.latch)
        begin
            func_reg   <= func_t'(func);
            hid_reg    <= handler_id;
            tmo_reg    <= timeout;
            cookie_reg <= cookie;
        end
        if (cmd.cap_slot)
        begin
            s_reg <= ord_rdata;
        end
        if (cmd.cap_other)
        begin
            other_reg <= ord_rdata;
        end
        if (cmd.fire && rec.hid != '0)
        begin
            pend_hid_reg    <= rec.hid;
            pend_cookie_reg <= rec.cookie;
        end
        out_kind_reg   <= out_kind_next;
        out_hid_reg    <= out_hid_next;
        out_cookie_reg <= out_cookie_next;
        out_last_reg   <= out_last_next;
    end

    // Status
    assign status.func      = func_reg;
    assign status.pool_full = (active_reg == CNT_W'(TIMER_SLOTS));
    assign status.walk_done = (n_reg == CNT_W'(TIMER_SLOTS));
    assign status.tmo_zero  = (rec.tmo == '0);
    assign status.hid_match = (rec.hid == hid_reg);

    assign result_valid  = out_valid_reg;
    assign kind          = out_kind_reg;
    assign fired_handler = out_hid_reg;
    assign fired_cookie  = out_cookie_reg;
    assign last          = out_last_reg;

endmodule

// ----- rtl/core/one_shot_timer_pool.sv -----
// Top level of the one-shot timer pool: sequencer plus datapath.
// Depends on ostp_pkg, ostp_ctrl, ostp_dp, one_shot_timer_pool_defines.svh.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------
//  request   | start in, busy out        | func, handler_id, timeout, cookie
//  result    | result_valid out (1 cyc)  | kind, fired_handler, fired_cookie, last
//
// A request is taken when start is high and busy is low.
// Start: dispatch, free-slot read, write. Cancel: dispatch, then read, slot and
// eval states per active slot. Tick: as Cancel, plus SWAP_A and SWAP_B per
// released slot; the single-port RAMs and their registered reads set these steps.
// Results leave one per cycle at most and cannot be stalled; last marks the end.
// Async reset empties the pool; no clearing pass is needed.
module one_shot_timer_pool (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ostp_pkg::FUNC_W-1:0]   func,
    input  logic [ostp_pkg::HID_W-1:0]    handler_id,
    input  logic [ostp_pkg::TMO_W-1:0]    timeout,
    input  logic [ostp_pkg::COOKIE_W-1:0] cookie,
    output logic                          busy,
    output logic                          result_valid,
    output logic [ostp_pkg::KIND_W-1:0]   kind,
    output logic [ostp_pkg::HID_W-1:0]    fired_handler,
    output logic [ostp_pkg::COOKIE_W-1:0] fired_cookie,
    output logic                          last
);
    import ostp_pkg::*;

`include "one_shot_timer_pool_defines.svh"

    ostp_cmd_t    cmd;
    ostp_status_t status;

    ostp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ostp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (func),
        .handler_id    (handler_id),
        .timeout       (timeout),
        .cookie        (cookie),
        .status        (status),
        .result_valid  (result_valid),
        .kind          (kind),
        .fired_handler (fired_handler),
        .fired_cookie  (fired_cookie),
        .last          (last)
    );

    // Checks
`OSTP_ASSERT_SAME(a_mid_result_fired, result_valid && !last, kind == KIND_FIRED, "non-final result is not a fire")
`OSTP_ASSERT_NEXT(a_more_follows, result_valid && !last, busy, "walk ended after a non-final result")
`OSTP_ASSERT_SAME(a_last_idle, result_valid && last, !busy, "final result while still busy")
`OSTP_ASSERT_NEXT(a_accept_quiet, start && !busy, busy && !result_valid, "result right after accept")

endmodule
